FILE: rtl/core/ibt_pkg.sv
// Shared types and constants for the interval booking table.
// No dependencies; imported by every module of the block.
package ibt_pkg;

    // Table size and derived widths
    localparam int ENTRIES  = 64;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 2 * TIME_W;
    localparam int OUT_W    = 8;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_BOOKED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    // Classified request as held in the queue
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              bad;
    } req_t;

    // One stored booking
    typedef struct packed {
        logic [TIME_W-1:0] begin_time;
        logic [TIME_W-1:0] finish_time;
    } slot_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        req_t req;
    } head_t;

endpackage

FILE: rtl/core/ibt_front.sv
// Front end: accepts booking requests, flags empty or reversed intervals
// and holds them in a two-entry queue. Depends on ibt_pkg.
module ibt_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ibt_pkg::IN_W-1:0] s_tdata,  // [31:0] start_time, [63:32] end_time
    output ibt_pkg::head_t          head,
    input  logic                    pop
);
    import ibt_pkg::*;

    req_t       q_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;
    req_t       in_req;

    // Classify the incoming item
    always_comb begin
        in_req.start_time = s_tdata[TIME_W-1:0];
        in_req.end_time   = s_tdata[IN_W-1:TIME_W];
        in_req.bad        = (s_tdata[TIME_W-1:0] >= s_tdata[IN_W-1:TIME_W]);
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != 2'd0);

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.req   = q_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/ibt_back.sv
// Back end: scans the booking memory one slot a cycle, decides the outcome,
// writes the new booking and holds the result item. Depends on ibt_pkg.
module ibt_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ibt_pkg::head_t            head,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ibt_pkg::OUT_W-1:0] m_tdata  // [0] accepted, [2:1] status
);
    import ibt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [IDX_W-1:0]    scan_cnt_reg, scan_cnt_next;
    req_t                req_reg;
    logic [ENTRIES-1:0]  slot_valid_reg;
    slot_t               mem [0:ENTRIES-1];
    slot_t               rd_data_reg;
    logic                pipe_live_reg;
    logic                pipe_vld_reg;
    logic [IDX_W-1:0]    pipe_idx_reg;
    logic                overlap_reg, overlap_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                out_valid_reg;
    logic                out_acc_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_free;
    logic                load_out;
    logic                res_acc;
    logic [STATUS_W-1:0] res_status;
    logic                wr_en;
    logic                hit;

    assign out_free = !out_valid_reg || m_tready;
    assign hit      = (req_reg.start_time < rd_data_reg.finish_time) &&
                      (rd_data_reg.begin_time < req_reg.end_time);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        pop           = 1'b0;
        load_out      = 1'b0;
        wr_en         = 1'b0;
        res_acc       = 1'b0;
        res_status    = ST_BOOKED;
        unique case (state_reg)
            S_IDLE: begin
                if (head.valid) begin
                    if (head.req.bad) begin
                        if (out_free) begin
                            pop        = 1'b1;
                            load_out   = 1'b1;
                            res_status = ST_INVALID;
                        end
                    end else begin
                        pop           = 1'b1;
                        scan_cnt_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_W'(ENTRIES - 1)) begin
                    scan_cnt_next = '0;
                    state_next    = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (overlap_reg) begin
                    res_status = ST_OVERLAP;
                end else if (!free_found_reg) begin
                    res_status = ST_FULL;
                end else begin
                    res_acc    = 1'b1;
                    res_status = ST_BOOKED;
                end
                if (out_free) begin
                    load_out   = 1'b1;
                    wr_en      = res_acc;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Accumulate overlap and the lowest free slot from the read pipe
    always_comb begin
        overlap_next    = overlap_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (pop) begin
            overlap_next    = 1'b0;
            free_found_next = 1'b0;
        end else if (pipe_live_reg) begin
            if (pipe_vld_reg) begin
                overlap_next = overlap_reg || hit;
            end else if (!free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = pipe_idx_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            pipe_live_reg  <= 1'b0;
            overlap_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end else begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            pipe_live_reg  <= (state_reg == S_SCAN);
            overlap_reg    <= overlap_next;
            free_found_reg <= free_found_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                slot_valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        free_idx_reg <= free_idx_next;
        pipe_idx_reg <= scan_cnt_reg;
        pipe_vld_reg <= slot_valid_reg[scan_cnt_reg];
        if (pop) begin
            req_reg <= head.req;
        end
        if (load_out) begin
            out_acc_reg    <= res_acc;
            out_status_reg <= res_status;
        end
    end

    // Booking memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[free_idx_reg] <= '{begin_time: req_reg.start_time,
                                   finish_time: req_reg.end_time};
        end
        rd_data_reg <= mem[scan_cnt_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - STATUS_W - 1){1'b0}}, out_status_reg, out_acc_reg};

    // A result that books a slot carries the booked status and nothing else
    a_acc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_acc_reg == (out_status_reg == ST_BOOKED)))
        else $error("accepted flag disagrees with status");

    // A new booking never lands on an occupied slot
    a_wr_free: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !slot_valid_reg[free_idx_reg])
        else $error("booking written over an occupied slot");

    // No free slot found means every slot is occupied
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !free_found_reg) |->
        ($countones(slot_valid_reg) == ENTRIES))
        else $error("table reported full with a free slot");

    // Requests leave the queue only between scans
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == S_IDLE && head.valid))
        else $error("queue popped during a scan");

endmodule

FILE: rtl/core/interval_booking_table_top.sv
// Interval booking table: a request [start_time, end_time) is checked against
// every stored booking and stored in the lowest free slot when nothing
// overlaps; otherwise it is refused with status overlap, full or invalid.
// A valid request passes through the back end in order: a pop step, one memory
// read per slot, a drain step for the last read and a decision and write step
// that waits while the output register is full; the single read port of the
// booking memory sets this. A request with start_time >= end_time is answered
// from idle without a scan. A two-entry queue takes new items while a scan is
// running and an output register holds the result item until it is taken.
// Reset clears all slots at once. Depends on ibt_pkg, ibt_front and ibt_back.
module interval_booking_table_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ibt_pkg::IN_W-1:0]  s_tdata,  // [31:0] start_time, [63:32] end_time
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ibt_pkg::OUT_W-1:0] m_tdata   // [0] accepted, [2:1] status, rest zero
);
    import ibt_pkg::*;

    head_t head;
    logic  pop;

    // Accept and classify
    ibt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    // Scan, book and report
    ibt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: verif/interval_booking_table_checker.sv
`timescale 1ns / 100ps
// Checker for the interval booking table: watches both item channels, keeps
// its own copy of the booking table and compares every result item in order.
// Depends on ibt_pkg for widths, table size and status codes.
module interval_booking_table_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [ibt_pkg::IN_W-1:0]  s_tdata,  // [31:0] start_time, [63:32] end_time
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [ibt_pkg::OUT_W-1:0] m_tdata,  // [0] accepted, [2:1] status
    output int                        fail_count,
    output int                        pending_items
);

    import ibt_pkg::*;

    typedef struct packed {
        logic                accepted;
        logic [STATUS_W-1:0] status;
    } verdict_t;

    // Shadow booking table and outstanding verdicts, oldest first
    logic              booked [ENTRIES];
    logic [TIME_W-1:0] booked_from [ENTRIES];
    logic [TIME_W-1:0] booked_to [ENTRIES];
    verdict_t          verdict_q [$];

    initial begin
        fail_count    = 0;
        pending_items = 0;
    end

    // Decide one request against the shadow table and store it when it fits
    function automatic verdict_t book_request(logic [TIME_W-1:0] req_from,
                                              logic [TIME_W-1:0] req_to);
        verdict_t v;
        logic     clash;
        int       free_slot;
        clash     = 1'b0;
        free_slot = -1;
        v.accepted = 1'b0;
        // empty or reversed interval is refused before any lookup
        if (req_from >= req_to) begin
            v.status = ST_INVALID;
            return v;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (booked[i]) begin
                if (req_from < booked_to[i] && booked_from[i] < req_to)
                    clash = 1'b1;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        // overlap wins over a full table
        if (clash) begin
            v.status = ST_OVERLAP;
        end else if (free_slot < 0) begin
            v.status = ST_FULL;
        end else begin
            booked[free_slot]      = 1'b1;
            booked_from[free_slot] = req_from;
            booked_to[free_slot]   = req_to;
            v.accepted = 1'b1;
            v.status   = ST_BOOKED;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    // Predict on every accepted request, compare on every accepted result
    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (!aresetn) begin
            verdict_q.delete();
            for (int i = 0; i < ENTRIES; i++)
                booked[i] = 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                verdict_q.push_back(book_request(s_tdata[TIME_W-1:0],
                                                 s_tdata[2*TIME_W-1:TIME_W]));
            if (m_tvalid && m_tready) begin
                got.accepted = m_tdata[0];
                got.status   = m_tdata[STATUS_W:1];
                if (verdict_q.size() == 0) begin
                    report_mismatch("result item with no request outstanding", -1,
                                    int'(got));
                end else begin
                    want = verdict_q.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", want.accepted, got.accepted);
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                end
            end
        end
        pending_items = verdict_q.size();
    end

endmodule

FILE: verif/interval_booking_table_top_test.sv
`timescale 1ns / 100ps
// Test top for the interval booking table: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on ibt_pkg, interval_booking_table_top and interval_booking_table_checker.
module interval_booking_table_top_test;

    import ibt_pkg::*;

    localparam int RANDOM_ITEMS = 590;
    localparam int IDLE_LIMIT   = 1000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    int   fail_count;
    int   pending_items;
    int   idle_cycles = 0;
    int   stall_left  = 0;
    logic result_taken = 1'b0;
    logic no_idle      = 1'b0;

    always #4 aclk = ~aclk;

    interval_booking_table_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    interval_booking_table_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_items (pending_items)
    );

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // Present one request; return at the falling edge after it is taken
    task automatic send_request(input logic [TIME_W-1:0] req_from,
                                input logic [TIME_W-1:0] req_to);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {req_to, req_from};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stall the result channel for a drawn number of cycles after each item
    always @(posedge aclk)
        result_taken <= m_tvalid && m_tready;

    always @(negedge aclk) begin
        int hold;
        hold = result_taken ? draw_gap() : stall_left;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold > 0) begin
            m_tready   <= 1'b0;
            stall_left <= hold - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end
    end

    // Count cycles in which neither channel moves an item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("interval_booking_table_top verification failed");
        $finish;
    end

    initial begin
        logic [TIME_W-1:0] cursor;
        logic [TIME_W-1:0] last_from;
        logic [TIME_W-1:0] last_to;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        int                pick;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty and reversed intervals at the extremes
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Bookings at both ends of the time range, then touching neighbours
        send_request(32'h0000_0000, 32'h0000_0001);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'h0000_0001, 32'h0000_000A);
        send_request(32'h0000_000A, 32'h0000_0014);
        send_request(32'hFFFF_FFF0, 32'hFFFF_FFFE);
        // Overlaps: inside, covering everything, at either boundary
        send_request(32'h0000_0005, 32'h0000_0006);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'h0000_0013, 32'h0000_0015);
        send_request(32'h0000_0009, 32'h0000_000A);
        send_request(32'hFFFF_FFFD, 32'hFFFF_FFFF);

        // Random part: mostly fresh bookings past a cursor and clustered
        // requests near them, so the table fills and then stays full
        cursor    = 32'd100;
        last_from = 32'd0;
        last_to   = 32'd1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = ((n / 50) % 4) == 3;
            // drain everything once midway
            if (n == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                wait (pending_items == 0);
                @(negedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                a         = cursor + $urandom_range(0, 3);
                b         = a + $urandom_range(1, 20);
                cursor    = b;
                last_from = a;
                last_to   = b;
            end else if (pick < 70) begin
                a = $urandom_range(100, cursor);
                b = a + $urandom_range(1, 30);
            end else if (pick < 78) begin
                a = last_from;
                b = last_to;
            end else if (pick < 90) begin
                a = $urandom;
                b = $urandom;
                if ($urandom_range(0, 3) == 0)
                    b = a;
                else if (a < b)
                    {a, b} = {b, a};
            end else begin
                a = $urandom;
                b = $urandom;
            end
            send_request(a, b);
        end
        s_tvalid <= 1'b0;

        // Let the last results drain, then watch for stray ones
        wait (pending_items == 0);
        repeat (ENTRIES + 8) @(posedge aclk);
        if (fail_count == 0 && pending_items == 0)
            $display("interval_booking_table_top verification clean");
        else
            $display("interval_booking_table_top verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ibt_pkg.sv
rtl/core/ibt_front.sv
rtl/core/ibt_back.sv
rtl/core/interval_booking_table_top.sv
verif/interval_booking_table_checker.sv
verif/interval_booking_table_top_test.sv
